>>> rtl/core/hlc_pkg.sv
// shared widths, defaults and types for the homogeneous line clipper
package hlc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int BC_W          = COORD_W + 1;
  localparam int NUM_W         = BC_W;
  localparam int DEN_W         = BC_W + 1;
  localparam int NPLANE        = 6;
  localparam int NAXIS         = 4;

  // item context carried alongside the divider pipeline
  typedef struct packed {
    logic [NAXIS-1:0][COORD_W-1:0] a;
    logic [NAXIS-1:0][COORD_W-1:0] b;
    logic [NPLANE-1:0]             oa;
    logic [NPLANE-1:0]             ob;
    logic [NPLANE-1:0]             hi;
    logic [NPLANE-1:0]             lo;
  } hlc_ctx_t;

endpackage

>>> rtl/core/hlc_div.sv
// pipelined restoring divider, one quotient bit per stage
module hlc_div #(
  parameter int FRAC_BITS = hlc_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic [hlc_pkg::NUM_W-1:0]  num,
  input  logic [hlc_pkg::DEN_W-1:0]  den,
  output logic [FRAC_BITS:0]         quo
);
  import hlc_pkg::*;

  localparam int REM_W = DEN_W + 1;
  localparam int Q_W   = FRAC_BITS + 1;

  logic [REM_W-1:0] rem_r [0:FRAC_BITS-1];
  logic [DEN_W-1:0] den_r [0:FRAC_BITS-1];
  logic [Q_W-1:0]   quo_r [0:FRAC_BITS];
  logic             ge0;

  // integer bit: set when the numerator is at least the divisor
  assign ge0 = (REM_W'(num) >= REM_W'(den));

  always_ff @(posedge clk) begin
    rem_r[0] <= ge0 ? (REM_W'(num) - REM_W'(den)) : REM_W'(num);
    den_r[0] <= den;
    quo_r[0] <= Q_W'(ge0) << FRAC_BITS;
  end

  // fraction bits, msb first
  for (genvar s = 1; s <= FRAC_BITS; s++) begin : g_stage
    logic [REM_W-1:0] shifted;
    logic             ge;
    assign shifted = rem_r[s-1] << 1;
    assign ge      = (shifted >= REM_W'(den_r[s-1]));

    always_ff @(posedge clk) begin
      quo_r[s] <= quo_r[s-1] | (ge ? (Q_W'(1) << (FRAC_BITS - s)) : Q_W'(0));
    end

    if (s < FRAC_BITS) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[s] <= ge ? (shifted - REM_W'(den_r[s-1])) : shifted;
        den_r[s] <= den_r[s-1];
      end
    end
  end

  assign quo = quo_r[FRAC_BITS];

endmodule

>>> rtl/core/homogeneous_line_clipper_unit.sv
// homogeneous line clipper: fully pipelined, one segment per cycle
// start passes the stage-1, divider, interval, product and output registers to out_valid
// throughput: one segment per cycle; busy is always low
// the divider stages, one quotient bit each, set the depth
// synchronous active-low reset clears the valid bits only
module homogeneous_line_clipper_unit #(
  parameter int FRAC_BITS = hlc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [hlc_pkg::COORD_W-1:0] in_ax,
  input  logic signed [hlc_pkg::COORD_W-1:0] in_ay,
  input  logic signed [hlc_pkg::COORD_W-1:0] in_az,
  input  logic signed [hlc_pkg::COORD_W-1:0] in_aw,
  input  logic signed [hlc_pkg::COORD_W-1:0] in_bx,
  input  logic signed [hlc_pkg::COORD_W-1:0] in_by,
  input  logic signed [hlc_pkg::COORD_W-1:0] in_bz,
  input  logic signed [hlc_pkg::COORD_W-1:0] in_bw,
  output logic                              out_valid,
  output logic                              out_kept,
  output logic signed [hlc_pkg::COORD_W-1:0] out_ax,
  output logic signed [hlc_pkg::COORD_W-1:0] out_ay,
  output logic signed [hlc_pkg::COORD_W-1:0] out_az,
  output logic signed [hlc_pkg::COORD_W-1:0] out_aw,
  output logic signed [hlc_pkg::COORD_W-1:0] out_bx,
  output logic signed [hlc_pkg::COORD_W-1:0] out_by,
  output logic signed [hlc_pkg::COORD_W-1:0] out_bz,
  output logic signed [hlc_pkg::COORD_W-1:0] out_bw
);
  import hlc_pkg::*;

  localparam int T_W = FRAC_BITS + 1;
  localparam int PW  = BC_W + T_W + 1;
  localparam int LAT = FRAC_BITS + 5;

  // ---------------- stage 1: boundary coords, outcodes, divider operands
  logic signed [COORD_W-1:0] pa [NAXIS];
  logic signed [COORD_W-1:0] pb [NAXIS];
  logic signed [BC_W-1:0]    ca [NPLANE];
  logic signed [BC_W-1:0]    cb [NPLANE];
  logic signed [DEN_W-1:0]   dd [NPLANE];
  hlc_ctx_t                  ctx_nxt;
  logic [NUM_W-1:0]          num_nxt [NPLANE];
  logic [DEN_W-1:0]          den_nxt [NPLANE];

  assign pa[0] = in_ax; assign pa[1] = in_ay; assign pa[2] = in_az; assign pa[3] = in_aw;
  assign pb[0] = in_bx; assign pb[1] = in_by; assign pb[2] = in_bz; assign pb[3] = in_bw;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ca[2*k]   = BC_W'(pa[3]) + BC_W'(pa[k]);
      ca[2*k+1] = BC_W'(pa[3]) - BC_W'(pa[k]);
      cb[2*k]   = BC_W'(pb[3]) + BC_W'(pb[k]);
      cb[2*k+1] = BC_W'(pb[3]) - BC_W'(pb[k]);
    end
    for (int k = 0; k < NAXIS; k++) begin
      ctx_nxt.a[k] = pa[k];
      ctx_nxt.b[k] = pb[k];
    end
    for (int k = 0; k < NPLANE; k++) begin
      dd[k]         = DEN_W'(ca[k]) - DEN_W'(cb[k]);
      ctx_nxt.oa[k] = ca[k][BC_W-1];
      ctx_nxt.ob[k] = cb[k][BC_W-1];
      ctx_nxt.hi[k] = cb[k][BC_W-1] && (ca[k] != cb[k]);
      ctx_nxt.lo[k] = !cb[k][BC_W-1] && ca[k][BC_W-1];
      num_nxt[k]    = ca[k][BC_W-1] ? NUM_W'(-ca[k]) : NUM_W'(ca[k]);
      den_nxt[k]    = dd[k][DEN_W-1] ? DEN_W'(-dd[k]) : DEN_W'(dd[k]);
    end
  end

  logic                s1_valid_r;
  hlc_ctx_t            s1_ctx_r;
  logic [NUM_W-1:0]    s1_num_r [NPLANE];
  logic [DEN_W-1:0]    s1_den_r [NPLANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctx_r <= ctx_nxt;
    s1_num_r <= num_nxt;
    s1_den_r <= den_nxt;
  end

  // ---------------- divider stages, one per plane, context delayed alongside
  logic [T_W-1:0] quo [NPLANE];

  for (genvar p = 0; p < NPLANE; p++) begin : g_div
    hlc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .num (s1_num_r[p]),
      .den (s1_den_r[p]),
      .quo (quo[p])
    );
  end

  logic     dv_valid_r [0:FRAC_BITS];
  hlc_ctx_t dv_ctx_r   [0:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= FRAC_BITS; s++) dv_valid_r[s] <= 1'b0;
    end else begin
      dv_valid_r[0] <= s1_valid_r;
      for (int s = 1; s <= FRAC_BITS; s++) dv_valid_r[s] <= dv_valid_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    dv_ctx_r[0] <= s1_ctx_r;
    for (int s = 1; s <= FRAC_BITS; s++) dv_ctx_r[s] <= dv_ctx_r[s-1];
  end

  // ---------------- interval narrowing
  hlc_ctx_t       dv_ctx;
  logic [T_W-1:0] t0_nxt;
  logic [T_W-1:0] t1_nxt;
  logic           rej_nxt;

  assign dv_ctx = dv_ctx_r[FRAC_BITS];

  always_comb begin
    t0_nxt = '0;
    t1_nxt = T_W'(1) << FRAC_BITS;
    for (int k = 0; k < NPLANE; k++) begin
      if (dv_ctx.hi[k] && (quo[k] < t1_nxt)) t1_nxt = quo[k];
      if (dv_ctx.lo[k] && (quo[k] > t0_nxt)) t0_nxt = quo[k];
    end
    rej_nxt = ((dv_ctx.oa & dv_ctx.ob) != '0) || (t0_nxt > t1_nxt);
  end

  logic           mm_valid_r;
  hlc_ctx_t       mm_ctx_r;
  logic [T_W-1:0] mm_t0_r;
  logic [T_W-1:0] mm_t1_r;
  logic           mm_rej_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_valid_r <= 1'b0;
    end else begin
      mm_valid_r <= dv_valid_r[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    mm_ctx_r <= dv_ctx;
    mm_t0_r  <= t0_nxt;
    mm_t1_r  <= t1_nxt;
    mm_rej_r <= rej_nxt;
  end

  // ---------------- delta times t
  logic signed [PW-1:0] pr0_nxt [NAXIS];
  logic signed [PW-1:0] pr1_nxt [NAXIS];

  always_comb begin
    for (int k = 0; k < NAXIS; k++) begin
      pr0_nxt[k] = PW'(signed'(BC_W'(signed'(mm_ctx_r.b[k])) - BC_W'(signed'(mm_ctx_r.a[k]))))
                 * PW'(signed'({1'b0, mm_t0_r}));
      pr1_nxt[k] = PW'(signed'(BC_W'(signed'(mm_ctx_r.b[k])) - BC_W'(signed'(mm_ctx_r.a[k]))))
                 * PW'(signed'({1'b0, mm_t1_r}));
    end
  end

  logic                 ml_valid_r;
  hlc_ctx_t             ml_ctx_r;
  logic                 ml_rej_r;
  logic signed [PW-1:0] ml_pr0_r [NAXIS];
  logic signed [PW-1:0] ml_pr1_r [NAXIS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ml_valid_r <= 1'b0;
    end else begin
      ml_valid_r <= mm_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    ml_ctx_r <= mm_ctx_r;
    ml_rej_r <= mm_rej_r;
    ml_pr0_r <= pr0_nxt;
    ml_pr1_r <= pr1_nxt;
  end

  // ---------------- floor shift, add, saturate, select
  logic signed [PW-1:0]      sum0 [NAXIS];
  logic signed [PW-1:0]      sum1 [NAXIS];
  logic signed [COORD_W-1:0] ra_nxt [NAXIS];
  logic signed [COORD_W-1:0] rb_nxt [NAXIS];

  localparam logic signed [PW-1:0] SAT_HI = PW'({1'b0, {(COORD_W-1){1'b1}}});
  localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

  always_comb begin
    for (int k = 0; k < NAXIS; k++) begin
      sum0[k] = PW'(signed'(ml_ctx_r.a[k])) + (ml_pr0_r[k] >>> FRAC_BITS);
      sum1[k] = PW'(signed'(ml_ctx_r.a[k])) + (ml_pr1_r[k] >>> FRAC_BITS);
      ra_nxt[k] = ml_ctx_r.a[k];
      rb_nxt[k] = ml_ctx_r.b[k];
      if (ml_ctx_r.oa != '0) begin
        if (sum0[k] > SAT_HI)      ra_nxt[k] = COORD_W'(SAT_HI);
        else if (sum0[k] < SAT_LO) ra_nxt[k] = COORD_W'(SAT_LO);
        else                       ra_nxt[k] = COORD_W'(sum0[k]);
      end
      if (ml_ctx_r.ob != '0) begin
        if (sum1[k] > SAT_HI)      rb_nxt[k] = COORD_W'(SAT_HI);
        else if (sum1[k] < SAT_LO) rb_nxt[k] = COORD_W'(SAT_LO);
        else                       rb_nxt[k] = COORD_W'(sum1[k]);
      end
      if (ml_rej_r) begin
        ra_nxt[k] = '0;
        rb_nxt[k] = '0;
      end
    end
  end

  logic                      out_valid_r;
  logic                      out_kept_r;
  logic signed [COORD_W-1:0] out_a_r [NAXIS];
  logic signed [COORD_W-1:0] out_b_r [NAXIS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ml_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_kept_r <= !ml_rej_r;
    out_a_r    <= ra_nxt;
    out_b_r    <= rb_nxt;
  end

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_kept  = out_kept_r;
  assign out_ax    = out_a_r[0];
  assign out_ay    = out_a_r[1];
  assign out_az    = out_a_r[2];
  assign out_aw    = out_a_r[3];
  assign out_bx    = out_b_r[0];
  assign out_by    = out_b_r[1];
  assign out_bz    = out_b_r[2];
  assign out_bw    = out_b_r[3];

  // ---------------- checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid) else $error("beat lost in pipeline");

  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT)) else $error("beat without a start");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_kept) |-> (out_ax == 0 && out_ay == 0 && out_az == 0 && out_aw == 0
      && out_bx == 0 && out_by == 0 && out_bz == 0 && out_bw == 0))
    else $error("rejected beat carries nonzero endpoints");

endmodule
